### design/text_console_writer_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console check failed");

// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console check failed");

`endif

### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Word types and constants of the text console writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] ATTR_RESET = 8'd36;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_word_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        screen_cleared;
  } rsp_word_t;

endpackage

### design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/text_console_writer_unit.sv
// A put or unused command passes its result word through the result register and then the
// output register; a read first passes S_READ for the registered RAM read; a clear, or a put
// that wraps past the last row, first walks the screen in S_CLEAR, one cell per cycle.
// A new command is taken only in S_IDLE with the result hand-off register empty.
// Reset: cursor homed, attribute 36, then a clearing pass over every cell of the
// screen RAM with cmd_ready low; configuration writes are taken during it.
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console over a screen RAM of attribute/character cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  tcw_pkg::cmd_word_t cmd_word,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tcw_pkg::rsp_word_t rsp_word,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  import tcw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EXT_W      = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ} state_t;

  state_t            state;
  logic [7:0]        attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] clr_addr;
  logic [15:0]       blank;
  logic              clr_report;
  logic              rd_in_range;
  logic              res_valid;
  rsp_word_t         res;

  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [ADDR_W-1:0] row_base_next;
  logic              start_clear;
  logic              accept;
  logic              is_newline;
  logic              put_write;
  logic [EXT_W-1:0]  idx_ext;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [15:0]       ram_rdata;

  assign cmd_ready  = (state == S_IDLE) && !res_valid;
  assign accept     = cmd_valid && cmd_ready;
  assign is_newline = (cmd_word.char_code == CH_NEWLINE) || (cmd_word.char_code == CH_RETURN);
  assign put_write  = accept && (cmd_word.cmd == CMD_PUT) && !is_newline;
  assign idx_ext    = EXT_W'(cmd_word.cell_index);

  always_comb begin
    col_next      = col;
    row_next      = row;
    row_base_next = row_base;
    start_clear   = 1'b0;
    if (accept) begin
      case (cmd_word.cmd)
        CMD_PUT: begin
          if (is_newline || (col == COL_W'(COLUMNS - 1))) begin
            col_next = '0;
            if (row == ROW_W'(ROWS - 1)) begin
              row_next      = '0;
              row_base_next = '0;
              start_clear   = 1'b1;
            end else begin
              row_next      = row + 1'b1;
              row_base_next = ADDR_W'(row_base + ADDR_W'(COLUMNS));
            end
          end else begin
            col_next = col + 1'b1;
          end
        end
        CMD_CLEAR: begin
          col_next      = '0;
          row_next      = '0;
          row_base_next = '0;
          start_clear   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = blank;
    end else begin
      ram_we    = put_write;
      ram_waddr = ADDR_W'(row_base + ADDR_W'(col));
      ram_wdata = {attr, cmd_word.char_code};
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_ext[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      col        <= '0;
      row        <= '0;
      row_base   <= '0;
      clr_addr   <= '0;
      blank      <= {ATTR_RESET, CH_SPACE};
      clr_report <= 1'b0;
      res_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      row_base <= row_base_next;

      if (res_valid && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
        rsp_word  <= res;
        res_valid <= 1'b0;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              res_valid <= 1'b1;
              res       <= '{cell_word: '0, cursor_col: '0, cursor_row: '0,
                             screen_cleared: 1'b1};
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (start_clear) begin
              state      <= S_CLEAR;
              clr_addr   <= '0;
              blank      <= {attr, CH_SPACE};
              clr_report <= 1'b1;
            end else if (cmd_word.cmd == CMD_READ) begin
              state       <= S_READ;
              rd_in_range <= idx_ext < EXT_W'(CELL_COUNT);
            end else begin
              res_valid <= 1'b1;
              res       <= '{cell_word: '0, cursor_col: 7'(col_next),
                             cursor_row: 5'(row_next), screen_cleared: 1'b0};
            end
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          res_valid <= 1'b1;
          res       <= '{cell_word: rd_in_range ? ram_rdata : 16'd0,
                         cursor_col: 7'(col), cursor_row: 5'(row), screen_cleared: 1'b0};
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_writer_unit_assert.svh"

module tcw_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input tcw_pkg::cmd_word_t cmd_word,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input tcw_pkg::rsp_word_t rsp_word
);

  import tcw_pkg::*;

  // stalled result word holds
  `TCW_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

  // a cleared screen homes the cursor and returns no cell
  `TCW_ASSERT_NOW(a_clear_home, clk, rst, rsp_valid && rsp_word.screen_cleared, (rsp_word.cursor_col == 7'd0) && (rsp_word.cursor_row == 5'd0) && (rsp_word.cell_word == 16'd0))

  // one command at a time
  `TCW_ASSERT_NEXT(a_one_at_a_time, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // a clear walks the screen before the next command
  `TCW_ASSERT_NEXT(a_clear_busy, clk, rst, cmd_valid && cmd_ready && (cmd_word.cmd == CMD_CLEAR), !cmd_ready && !(rsp_valid && rsp_word.screen_cleared && !$past(rsp_valid)))

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

### dv/text_console_writer_unit_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Drives put, clear, read and unused command words into the console, with
// random bursts on the command side and random stalls on the result side.
// A behavioral screen image is updated as each command is accepted, and each
// result word is checked field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int COLS       = 80;
  localparam int LINES      = 25;
  localparam int CELLS      = COLS * LINES;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cmd_valid   = 1'b0;
  logic       cmd_ready;
  cmd_word_t  cmd_word    = '0;
  logic       rsp_valid;
  logic       rsp_ready   = 1'b0;
  rsp_word_t  rsp_word;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  // screen image and cursor
  logic [15:0] screen_img [0:CELLS-1];
  logic [7:0]  console_attr;
  int          cur_col;
  int          cur_row;

  cmd_word_t   cmd_backlog[$];
  rsp_word_t   cursor_reports[$];
  int unsigned gen_count    = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_checked    = 0;
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;
  logic        cmd_taken    = 1'b0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          stall_mode   = 0;
  int          stall_span   = 0;

  text_console_writer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd_word    (cmd_word),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp_word    (rsp_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void console_blank();
    for (int i = 0; i < CELLS; i++) begin
      screen_img[i] = {console_attr, CH_SPACE};
    end
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic logic console_newline();
    logic wrapped;
    wrapped = 1'b0;
    cur_row++;
    if (cur_row >= LINES) begin
      console_blank();
      wrapped = 1'b1;
    end
    cur_col = 0;
    return wrapped;
  endfunction

  function automatic rsp_word_t console_apply(cmd_word_t w);
    rsp_word_t r;
    logic      wrapped;
    r = '0;
    wrapped = 1'b0;
    case (w.cmd)
      CMD_PUT: begin
        if (w.char_code == CH_NEWLINE || w.char_code == CH_RETURN) begin
          wrapped = console_newline();
        end else begin
          screen_img[cur_row * COLS + cur_col] = {console_attr, w.char_code};
          cur_col++;
          if (cur_col >= COLS) wrapped = console_newline();
        end
      end
      CMD_CLEAR: begin
        console_blank();
        wrapped = 1'b1;
      end
      CMD_READ: begin
        if (w.cell_index < CELLS) r.cell_word = screen_img[w.cell_index];
      end
      default: ;
    endcase
    r.cursor_col     = cur_col[6:0];
    r.cursor_row     = cur_row[4:0];
    r.screen_cleared = wrapped;
    return r;
  endfunction

  task automatic check_field(string fname, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      err_count++;
    end
  endtask

  task automatic add_cmd(logic [1:0] c, logic [7:0] ch, logic [10:0] idx);
    cmd_word_t w;
    w.cmd        = c;
    w.char_code  = ch;
    w.cell_index = idx;
    cmd_backlog.push_back(w);
    gen_count++;
  endtask

  task automatic fill_random(int unsigned n);
    int unsigned stop_at;
    int          kind;
    int          len;
    stop_at = gen_count + n;
    while (gen_count < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 52) begin
        len = $urandom_range(1, 14);
        repeat (len) begin
          add_cmd(CMD_PUT, 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(32, 126)),
                  11'($urandom));
        end
        if ($urandom_range(0, 1) == 1) begin
          add_cmd(CMD_PUT, $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN, 11'($urandom));
        end
      end else if (kind < 72) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          add_cmd(CMD_READ, 8'($urandom),
                  11'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, 319)));
        end
      end else if (kind < 78) begin
        add_cmd(CMD_UNUSED, 8'($urandom), 11'($urandom));
      end else if (kind < 84) begin
        add_cmd(CMD_CLEAR, 8'($urandom), 11'($urandom));
      end else if (kind < 92) begin
        // enough line breaks to run off the bottom from any row
        repeat (LINES + 1) begin
          add_cmd(CMD_PUT, $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN, 11'($urandom));
        end
      end else begin
        repeat (COLS + 2) add_cmd(CMD_PUT, 8'($urandom_range(0, 255)), 11'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_valid || n_accepted != n_checked);
  endtask

  task automatic set_attribute(logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    console_attr = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // command driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        cmd_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd_word  <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       rsp_ready <= 1'b1;
      1:       rsp_ready <= ($urandom_range(0, 3) != 0);
      2:       rsp_ready <= 1'($urandom_range(0, 1));
      default: rsp_ready <= ((stall_span % 32) < 8);
    endcase
  end

  // monitor and checker
  always @(posedge clk) begin
    rsp_word_t want;
    cmd_taken <= !rst && cmd_valid && cmd_ready;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (cursor_reports.size() == 0) begin
          $display("%0t: result word with none expected, actual 0x%0h", $time, rsp_word);
          err_count++;
        end else begin
          want = cursor_reports.pop_front();
          check_field("cell_word", rsp_word.cell_word, want.cell_word);
          check_field("cursor_col", 16'(rsp_word.cursor_col), 16'(want.cursor_col));
          check_field("cursor_row", 16'(rsp_word.cursor_row), 16'(want.cursor_row));
          check_field("screen_cleared", 16'(rsp_word.screen_cleared),
                      16'(want.screen_cleared));
        end
        n_checked <= n_checked + 1;
      end
      if (cmd_valid && cmd_ready) begin
        cursor_reports.push_back(console_apply(cmd_word));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    console_attr = ATTR_RESET;
    console_blank();

    // byte extremes, line breaks, reads in and out of range
    add_cmd(CMD_PUT, 8'h48, 11'h000);
    add_cmd(CMD_PUT, 8'h00, 11'h7FF);
    add_cmd(CMD_PUT, 8'hFF, 11'h000);
    add_cmd(CMD_PUT, 8'h80, 11'h555);
    add_cmd(CMD_PUT, 8'h7F, 11'h2AA);
    add_cmd(CMD_READ, 8'h00, 11'd0);
    add_cmd(CMD_READ, 8'hFF, 11'd1);
    add_cmd(CMD_READ, 8'h00, 11'd2);
    add_cmd(CMD_READ, 8'h00, 11'd3);
    add_cmd(CMD_READ, 8'h00, 11'd4);
    add_cmd(CMD_PUT, CH_NEWLINE, 11'd0);
    add_cmd(CMD_PUT, CH_RETURN, 11'd0);
    add_cmd(CMD_READ, 8'h00, 11'd5);
    add_cmd(CMD_READ, 8'h00, 11'(CELLS - 1));
    add_cmd(CMD_READ, 8'h00, 11'(CELLS));
    add_cmd(CMD_READ, 8'h00, 11'h7FF);
    add_cmd(CMD_UNUSED, 8'hFF, 11'h7FF);
    add_cmd(CMD_UNUSED, 8'h00, 11'h000);
    add_cmd(CMD_CLEAR, 8'hFF, 11'h7FF);
    add_cmd(CMD_READ, 8'h00, 11'd0);
    add_cmd(CMD_PUT, 8'h55, 11'd0);
    add_cmd(CMD_PUT, 8'hAA, 11'd0);
    add_cmd(CMD_READ, 8'h00, 11'd0);
    add_cmd(CMD_READ, 8'h00, 11'd1);
    fill_random(110);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait_drained();
    set_attribute(8'h00);
    fill_random(110);
    wait_drained();
    set_attribute(8'hFF);
    fill_random(110);
    wait_drained();
    set_attribute(8'($urandom_range(1, 254)));
    fill_random(110);
    wait_drained();

    repeat (40) @(posedge clk);
    @(negedge clk);
    if (err_count == 0 && cursor_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### text_console_writer_unit.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer_unit.sv
design/tcw_checker.sv
dv/text_console_writer_unit_tb.sv
